// ----- src/sequential_list_engine_core_assert.svh -----
// Assertion macros shared by the list engine. Each macro expects clk and rst
// to be visible where it is used.
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sle_pkg.sv -----
package sle_pkg;

  // Store geometry.
  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int ENTRY_W = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Compare width wide enough for count, capacity and position plus one.
  localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

  // Stream packing.
  localparam int IN_FIELDS  = CMD_W + POS_W + VAL_W;
  localparam int IN_W       = ((IN_FIELDS + 7) / 8) * 8;
  localparam int OUT_FIELDS = ST_W + VAL_W + ENTRY_W + 2;
  localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_REVERSE = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    STS_OK     = 2'd0,
    STS_BADPOS = 2'd1,
    STS_FULL   = 2'd2,
    STS_EMPTY  = 2'd3
  } sts_t;

  // Outcome of the command check.
  typedef enum logic [1:0] {
    DEC_FAIL,
    DEC_INS,
    DEC_DEL,
    DEC_REV
  } dec_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_FETCH,
    RD_UP,
    RD_DOWN,
    RD_PAIR
  } rd_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_VAL,
    WR_REV_LO
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_MOVE,
    S_INS_DRAIN,
    S_INS_PUT,
    S_DEL_FETCH,
    S_DEL_MOVE,
    S_DEL_DRAIN,
    S_REV_RD,
    S_REV_WR,
    S_REV_LAST,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    init;
    rd_t     rd;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    load_out;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    dec_t dec;
    logic ins_nomove;
    logic rev_short;
    logic at_k;
    logic at_top;
    logic rev_more;
    logic out_free;
    logic wr_pending;
  } dp_sts_t;

endpackage

// ----- src/sequential_list_engine_core.sv -----
// Items are taken one at a time. The walk over the entry RAM, one entry per cycle
// through its single write port, sets how long an item takes; a failed command
// skips the walk. The result stays valid until taken, and one new item is
// accepted meanwhile. Reset (rst, synchronous, active high) empties the list,
// sets the capacity to 16 and drops any pending result; entries are not cleared.
module sequential_list_engine_core (
  input  logic                     clk,
  input  logic                     rst,
  // Capacity register.
  input  logic                     cfg_we,
  input  logic [sle_pkg::CAP_W-1:0] cfg_wdata,
  // Commands in.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // command[1:0], position[6:2], value[38:7], zero pad above.
  input  logic [sle_pkg::IN_W-1:0]  s_axis_tdata,
  // Results out.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // status[1:0], removed_value[33:2], entry_count[38:34], is_empty[39],
  // is_full[40], zero pad above.
  output logic [sle_pkg::OUT_W-1:0] m_axis_tdata
);
  import sle_pkg::*;

  `include "sequential_list_engine_core_assert.svh"

  dp_ctl_t ctl;
  dp_sts_t sts;

  // The controller sequences each command: a check cycle that classifies the
  // command against the current count and capacity, then the shifting or
  // swapping walk over the RAM, then a cycle that loads the result register.
  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // The datapath holds the entry RAM, the count, the capacity register, the
  // walk pointers and the output register. Inserts shift entries up from the
  // top down, deletes shift entries down after fetching the removed word, and
  // reverse reads both ends at once and writes the low end, then the high end, back.
  sle_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata[IN_FIELDS-1:0]),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // A pending result must never be overwritten before it is taken.
  `SLE_ASSERT_NOW(a_out_not_lost, ctl.load_out, (!m_axis_tvalid || m_axis_tready), "result lost")
  // The controller never claims the RAM write port while a shift or swap write is due.
  `SLE_ASSERT_NOW(a_one_write, sts.wr_pending, (ctl.wr_sel == WR_NONE), "write port conflict")
  // Only one item is in work at a time.
  `SLE_ASSERT_NEXT(a_one_item, (s_axis_tvalid && s_axis_tready), !s_axis_tready, "second item taken")

endmodule

// ----- src/sle_ctrl.sv -----
module sle_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sle_pkg::dp_sts_t sts,
  output sle_pkg::dp_ctl_t ctl
);
  import sle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        unique case (sts.dec)
          DEC_INS: state_next = sts.ins_nomove ? S_INS_PUT : S_INS_MOVE;
          DEC_DEL: state_next = S_DEL_FETCH;
          DEC_REV: state_next = sts.rev_short ? S_DONE : S_REV_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_INS_MOVE: begin
        if (sts.at_k) state_next = S_INS_DRAIN;
      end
      S_INS_DRAIN: state_next = S_INS_PUT;
      S_INS_PUT:   state_next = S_DONE;
      S_DEL_FETCH: state_next = sts.at_top ? S_DEL_DRAIN : S_DEL_MOVE;
      S_DEL_MOVE: begin
        if (sts.at_top) state_next = S_DEL_DRAIN;
      end
      S_DEL_DRAIN: state_next = S_DONE;
      S_REV_RD:    state_next = S_REV_WR;
      S_REV_WR:    state_next = sts.rev_more ? S_REV_RD : S_REV_LAST;
      S_REV_LAST:  state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctl.load_item = 1'b0;
    ctl.init      = 1'b0;
    ctl.rd        = RD_NONE;
    ctl.wr_sel    = WR_NONE;
    ctl.cnt_op    = CNT_HOLD;
    ctl.load_out  = 1'b0;
    unique case (state)
      S_IDLE: begin
        // No item is taken while reset is held.
        in_ready      = !rst;
        ctl.load_item = in_valid && !rst;
      end
      S_CHECK:     ctl.init = 1'b1;
      S_INS_MOVE:  ctl.rd = RD_UP;
      S_INS_PUT: begin
        ctl.wr_sel = WR_VAL;
        ctl.cnt_op = CNT_INC;
      end
      S_DEL_FETCH: ctl.rd = RD_FETCH;
      S_DEL_MOVE:  ctl.rd = RD_DOWN;
      S_DEL_DRAIN: ctl.cnt_op = CNT_DEC;
      S_REV_RD:    ctl.rd = RD_PAIR;
      S_REV_WR:    ctl.wr_sel = WR_REV_LO;
      S_DONE:      ctl.load_out = sts.out_free;
      default: begin
      end
    endcase
  end

endmodule

// ----- src/sle_datapath.sv -----
module sle_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sle_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic [sle_pkg::IN_FIELDS-1:0] in_data,
  input  sle_pkg::dp_ctl_t              ctl,
  output sle_pkg::dp_sts_t              sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sle_pkg::OUT_W-1:0]     out_data
);
  import sle_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0] cap;
  logic [CW-1:0]    count;
  cmd_t             cmd_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [AW-1:0]    k;
  logic [AW-1:0]    rp;
  logic [AW-1:0]    wp;
  logic [AW-1:0]    lo;
  logic [AW-1:0]    hi;
  logic [AW-1:0]    hw;
  logic [VAL_W-1:0] rda;
  logic [VAL_W-1:0] rdb;
  logic [VAL_W-1:0] hold;
  logic [VAL_W-1:0] removed;
  sts_t             res_status;
  logic             wv;
  logic             hv;
  logic             rm_pend;

  logic [CMP_W-1:0] cap_x;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] count_x;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] k_sel;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    top;
  logic [AW:0]      span;
  logic [AW-1:0]    ra;
  logic             full;
  dec_t             dec;
  sts_t             dec_status;

  assign cap_x   = CMP_W'(cap);
  assign eff_cap = (cap_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_x;
  assign count_x = CMP_W'(count);
  assign pos_x   = CMP_W'(pos_q);
  assign full    = count_x >= eff_cap;
  assign cnt_m1  = count - CW'(1);
  assign top     = cnt_m1[AW-1:0];
  assign span    = {1'b0, hi} - {1'b0, lo};
  assign ra      = (ctl.rd == RD_PAIR) ? lo : rp;

  // Position is checked before fullness on insert.
  always_comb begin
    dec        = DEC_FAIL;
    dec_status = STS_OK;
    k_sel      = '0;
    unique case (cmd_q)
      CMD_APPEND: begin
        if (full) begin
          dec_status = STS_FULL;
        end else begin
          dec   = DEC_INS;
          k_sel = count_x;
        end
      end
      CMD_INSERT: begin
        if (pos_x == '0 || pos_x > count_x + CMP_W'(1)) begin
          dec_status = STS_BADPOS;
        end else if (full) begin
          dec_status = STS_FULL;
        end else begin
          dec   = DEC_INS;
          k_sel = pos_x - CMP_W'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_x == '0 || pos_x > count_x) begin
          dec_status = STS_BADPOS;
        end else begin
          dec   = DEC_DEL;
          k_sel = pos_x - CMP_W'(1);
        end
      end
      CMD_REVERSE: begin
        if (count_x == '0) begin
          dec_status = STS_EMPTY;
        end else begin
          dec = DEC_REV;
        end
      end
    endcase
  end

  assign sts.dec        = dec;
  assign sts.ins_nomove = (k_sel == count_x);
  assign sts.rev_short  = (count_x < CMP_W'(2));
  assign sts.at_k       = (rp == k);
  assign sts.at_top     = (rp == top);
  assign sts.rev_more   = (span > (AW + 1)'(2));
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.wr_pending = wv || hv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
      wv        <= 1'b0;
      hv        <= 1'b0;
      rm_pend   <= 1'b0;
    end else begin
      if (cfg_we) cap <= cfg_wdata;
      unique case (ctl.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
      wv      <= (ctl.rd == RD_UP) || (ctl.rd == RD_DOWN);
      rm_pend <= (ctl.rd == RD_FETCH);
      hv      <= (ctl.wr_sel == WR_REV_LO);
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q <= cmd_t'(in_data[CMD_W-1:0]);
      pos_q <= in_data[CMD_W +: POS_W];
      val_q <= in_data[CMD_W + POS_W +: VAL_W];
    end
    if (ctl.init) begin
      k          <= k_sel[AW-1:0];
      res_status <= dec_status;
      removed    <= '0;
      lo         <= '0;
      hi         <= top;
      rp         <= (cmd_q == CMD_DELETE) ? k_sel[AW-1:0] : top;
    end
    unique case (ctl.rd)
      RD_FETCH: begin
        rda <= mem[ra];
        rp  <= rp + AW'(1);
      end
      RD_UP: begin
        rda <= mem[ra];
        wp  <= rp + AW'(1);
        rp  <= rp - AW'(1);
      end
      RD_DOWN: begin
        rda <= mem[ra];
        wp  <= rp - AW'(1);
        rp  <= rp + AW'(1);
      end
      RD_PAIR: begin
        rda <= mem[ra];
        rdb <= mem[hi];
      end
      default: begin
      end
    endcase
    if (rm_pend) removed <= rda;
    if (ctl.wr_sel == WR_REV_LO) begin
      hold <= rda;
      hw   <= hi;
      lo   <= lo + AW'(1);
      hi   <= hi - AW'(1);
    end
    if (ctl.load_out) begin
      out_data <= {(OUT_W - OUT_FIELDS)'(0), full, (count == '0), ENTRY_W'(count),
                   removed, res_status};
    end
  end

  // Single write port: shift writes first, then the held reverse word,
  // then the writes the controller asks for.
  always_ff @(posedge clk) begin
    priority if (wv) begin
      mem[wp] <= rda;
    end else if (hv) begin
      mem[hw] <= hold;
    end else if (ctl.wr_sel == WR_VAL) begin
      mem[k] <= val_q;
    end else if (ctl.wr_sel == WR_REV_LO) begin
      mem[lo] <= rdb;
    end
  end

endmodule
